// ===== rtl/brb_pkg.sv =====
// Package for the byte ring buffer: field widths, operation and status codes,
// default sizes and the control structs shared by the controller and datapath.
// No dependencies; every other file of the block but brb_ram imports it.
`default_nettype none

package brb_pkg;

  localparam int LEN_W     = 13;
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int DEPTH_DEF     = 4096;
  localparam int MAX_BURST_DEF = 64;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [BYTE_W-1:0]   byte_t;

  localparam kind_t KIND_PUT   = 3'd0;
  localparam kind_t KIND_GET   = 3'd1;
  localparam kind_t KIND_PEEK  = 3'd2;
  localparam kind_t KIND_DROP  = 3'd3;
  localparam kind_t KIND_CLEAR = 3'd4;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_NONE = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  localparam len_t RUN_MAX = 13'h1FFF;

  // Register index taken from the word address bits of paddr.
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic ready;
    logic accept;
    logic start;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic burst_req;
    logic s1_valid;
    logic out_free;
    logic issue_last;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/brb_if.sv =====
// Valid/ready channel interfaces for the byte ring buffer's request and result.
// Depends on brb_pkg for the payload types.
`default_nettype none

interface brb_in_if;
  import brb_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t data_byte;
  logic  data_last;
  len_t  request_len;

  modport source (output valid, kind, data_byte, data_last, request_len, input ready);
  modport sink   (input valid, kind, data_byte, data_last, request_len, output ready);
endinterface

interface brb_out_if;
  import brb_pkg::*;

  logic    valid;
  logic    ready;
  byte_t   byte_out;
  status_t status;
  len_t    done_count;
  logic    last;
  len_t    fill_count;
  logic    is_empty;
  logic    is_full;

  modport source (output valid, byte_out, status, done_count, last, fill_count, is_empty,
                  is_full, input ready);
  modport sink   (input valid, byte_out, status, done_count, last, fill_count, is_empty,
                  is_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/byte_ring_buffer.sv =====
// Top level of the byte ring buffer: APB register port, controller and datapath.
// Depends on brb_pkg, brb_if, brb_ctrl, brb_dp and brb_ram.
//
//   Channel   Role    Handshake          Carries
//   cmd       sink    valid/ready        kind, data_byte, data_last, request_len
//   rsp       source  valid/ready        byte_out, status, done_count, last, fill, flags
//   APB       slave   psel/penable       capacity register at byte address 0
//
// Put, clear, drop and rejected requests follow back to back while results are taken.
// A get or peek sends up to MAX_BURST held bytes from the store's registered read port,
// one per cycle while results are taken; the read stage drains before the next is taken.
// Reset is synchronous; the store needs no clearing pass, since entries are read only
// after they are written. A stalled result holds the output register, and no new
// transaction is taken until it can move.
`default_nettype none

module byte_ring_buffer #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brb_pkg::APB_AW-1:0]  paddr,
  input  logic [brb_pkg::APB_DW-1:0]  pwdata,
  output logic [brb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  brb_in_if.sink                      cmd,
  brb_out_if.source                   rsp
);
  import brb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  ctrl_cmd_t     ccmd;
  ctrl_stat_t    cstat;
  logic [CW-1:0] capacity;
  logic          reg_hit;
  logic          cfg_we;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_CAPACITY);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? APB_DW'(capacity) : '0;

  assign cmd.ready = ccmd.ready;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .stat     (cstat),
    .cmd      (ccmd)
  );

  brb_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[LEN_W-1:0]),
    .capacity    (capacity),
    .kind        (cmd.kind),
    .data_byte   (cmd.data_byte),
    .data_last   (cmd.data_last),
    .request_len (cmd.request_len),
    .cmd         (ccmd),
    .stat        (cstat),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .byte_out    (rsp.byte_out),
    .status      (rsp.status),
    .done_count  (rsp.done_count),
    .last        (rsp.last),
    .fill_count  (rsp.fill_count),
    .is_empty    (rsp.is_empty),
    .is_full     (rsp.is_full)
  );

endmodule

`default_nettype wire

// ===== rtl/brb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brb_ctrl.sv =====
// Controller of the byte ring buffer: sequences single-result operations and
// read bursts. Depends on brb_pkg for the command and status structs.
`default_nettype none

module brb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  brb_pkg::ctrl_stat_t    stat,
  output brb_pkg::ctrl_cmd_t     cmd
);
  import brb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BURST = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        // A new transaction waits until the read stage is drained and the
        // output register can take a result.
        cmd.ready  = !stat.s1_valid && stat.out_free;
        cmd.accept = cmd.ready && in_valid;
        cmd.start  = cmd.accept && stat.burst_req;
        if (cmd.start) begin
          state_next = S_BURST;
        end
      end
      S_BURST: begin
        cmd.issue  = !stat.s1_valid || stat.out_free;
        cmd.finish = cmd.issue && stat.issue_last;
        if (cmd.finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brb_dp.sv =====
// Datapath of the byte ring buffer: pointers, fill count, byte store, read
// stage and output register. Depends on brb_pkg and brb_ram.
`default_nettype none

module brb_dp #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEF,
  parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  brb_pkg::len_t                  cfg_wdata,
  output logic [$clog2(DEPTH+1)-1:0]     capacity,
  input  brb_pkg::kind_t                 kind,
  input  brb_pkg::byte_t                 data_byte,
  input  logic                           data_last,
  input  brb_pkg::len_t                  request_len,
  input  brb_pkg::ctrl_cmd_t             cmd,
  output brb_pkg::ctrl_stat_t            stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output brb_pkg::byte_t                 byte_out,
  output brb_pkg::status_t               status,
  output brb_pkg::len_t                  done_count,
  output logic                           last,
  output brb_pkg::len_t                  fill_count,
  output logic                           is_empty,
  output logic                           is_full
);
  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int XW = (CW > LEN_W) ? CW : LEN_W;
  localparam int BW = $clog2(MAX_BURST + 1);

  logic [AW-1:0] write_index, write_index_next;
  logic [AW-1:0] read_index, read_index_next;
  logic [CW-1:0] held, held_next;
  len_t          run_count, run_count_next;

  logic [AW-1:0] rd_ptr;
  logic [BW-1:0] burst_n;
  logic [BW-1:0] burst_i;
  logic          burst_get;
  logic          s1_valid;
  logic          s1_last;
  logic          s1_move;
  byte_t         ram_rdata;
  logic          ram_we;

  logic [XW-1:0] req_x, held_x, drop_n, burst_cap, burst_x, cfg_x;
  logic [SW-1:0] rd_sum, rd_wrap;
  logic          room;
  logic          run_inc;
  len_t          run_after;
  status_t       r_status;
  len_t          r_done;
  logic          r_last;
  logic [CW-1:0] cap_wr;

  function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] p,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] inc;
    inc = CW'(p) + CW'(1);
    return (inc >= cap) ? '0 : AW'(inc);
  endfunction

  always_comb begin
    cfg_x = XW'(cfg_wdata);
    if (cfg_wdata == '0) begin
      cap_wr = CW'(1);
    end else if (cfg_x > XW'(DEPTH)) begin
      cap_wr = CW'(DEPTH);
    end else begin
      cap_wr = CW'(cfg_x);
    end
  end

  always_comb begin
    req_x     = XW'(request_len);
    held_x    = XW'(held);
    room      = held < capacity;
    run_inc   = room && (run_count != RUN_MAX);
    run_after = run_count + LEN_W'(run_inc);
    drop_n    = (req_x > held_x) ? held_x : req_x;
    burst_cap = (req_x > XW'(MAX_BURST)) ? XW'(MAX_BURST) : req_x;
    burst_x   = (burst_cap > held_x) ? held_x : burst_cap;
    // The read index is below capacity and drop_n is at most capacity, so one
    // conditional subtract gives the wrapped index.
    rd_sum    = SW'(read_index) + SW'(drop_n);
    rd_wrap   = (rd_sum >= SW'(capacity)) ? rd_sum - SW'(capacity) : rd_sum;

    write_index_next = write_index;
    read_index_next  = read_index;
    held_next        = held;
    run_count_next   = run_count;
    ram_we           = 1'b0;
    r_status         = ST_DONE;
    r_done           = '0;
    r_last           = 1'b1;

    case (kind)
      KIND_PUT: begin
        ram_we = room;
        if (room) begin
          write_index_next = step_idx(write_index, capacity);
          held_next        = held + CW'(1);
        end
        r_done = run_after;
        if (data_last) begin
          run_count_next = '0;
          r_status       = (run_after == '0) ? ST_NONE : ST_DONE;
        end else begin
          run_count_next = run_after;
          r_status       = room ? ST_DONE : ST_NONE;
          r_last         = 1'b0;
        end
      end
      KIND_CLEAR: begin
        write_index_next = '0;
        read_index_next  = '0;
        held_next        = '0;
      end
      KIND_DROP: begin
        if (request_len == '0) begin
          r_status = ST_BAD;
        end else if (held == '0) begin
          r_status = ST_NONE;
        end else begin
          read_index_next = AW'(rd_wrap);
          held_next       = held - CW'(drop_n);
          r_done          = LEN_W'(drop_n);
        end
      end
      KIND_GET, KIND_PEEK: begin
        if (request_len == '0) begin
          r_status = ST_BAD;
        end else if (held == '0) begin
          r_status = ST_NONE;
        end else if (kind == KIND_GET) begin
          held_next = held - CW'(burst_x);
        end
      end
      default: begin
        r_status = ST_BAD;
      end
    endcase
  end

  assign s1_move = s1_valid && (!out_valid || out_ready);

  always_comb begin
    stat.burst_req  = (kind inside {KIND_GET, KIND_PEEK}) && (request_len != '0) &&
                      (held != '0);
    stat.s1_valid   = s1_valid;
    stat.out_free   = !out_valid || out_ready;
    stat.issue_last = (BW'(burst_i + BW'(1)) == burst_n);
  end

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept && ram_we),
    .waddr (write_index),
    .wdata (data_byte),
    .re    (cmd.issue),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // Pointer and fill state.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CW'(DEPTH);
      write_index <= '0;
      read_index  <= '0;
      held        <= '0;
      run_count   <= '0;
    end else if (cfg_we) begin
      capacity    <= cap_wr;
      write_index <= '0;
      read_index  <= '0;
      held        <= '0;
      run_count   <= '0;
    end else if (cmd.accept) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      held        <= held_next;
      run_count   <= run_count_next;
    end else if (cmd.finish && burst_get) begin
      read_index  <= step_idx(rd_ptr, capacity);
    end
  end

  // Burst sequencing registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_ptr    <= read_index;
      burst_n   <= BW'(burst_x);
      burst_i   <= '0;
      burst_get <= (kind == KIND_GET);
    end else if (cmd.issue) begin
      rd_ptr    <= step_idx(rd_ptr, capacity);
      burst_i   <= burst_i + BW'(1);
    end
    if (cmd.issue) begin
      s1_last <= stat.issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.issue) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Output register: a single result at each accept that starts no burst, or one burst byte per move.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && !cmd.start) || s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      byte_out   <= ram_rdata;
      status     <= ST_DONE;
      done_count <= LEN_W'(burst_n);
      last       <= s1_last;
      fill_count <= LEN_W'(held);
      is_empty   <= (held == '0);
      is_full    <= (held == capacity);
    end else if (cmd.accept && !cmd.start) begin
      byte_out   <= '0;
      status     <= r_status;
      done_count <= r_done;
      last       <= r_last;
      fill_count <= LEN_W'(held_next);
      is_empty   <= (held_next == '0);
      is_full    <= (held_next == capacity);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brb_chk.sv =====
// Port-level checker for the byte ring buffer, bound to the top level.
// Depends on brb_pkg for the status codes.
`default_nettype none

module brb_chk (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input brb_pkg::byte_t byte_out,
  input brb_pkg::status_t status,
  input brb_pkg::len_t  done_count,
  input logic           last,
  input brb_pkg::len_t  fill_count,
  input logic           is_empty,
  input logic           is_full
);
  import brb_pkg::*;

  // A result waiting on the sink holds its byte, status, done count, last flag and fill count.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(status) &&
      $stable(done_count) && $stable(last) && $stable(fill_count))
    else $error("result changed while stalled");

  // With only one output slot, nothing new may be taken while it is blocked.
  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("transaction taken while the result is stalled");

  a_bad_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD |-> last && done_count == '0)
    else $error("bad request result is not a lone final result");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (fill_count == '0)))
    else $error("empty flag disagrees with fill count");

  // Capacity is at least one, so the store is never empty and full at once.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_empty && is_full))
    else $error("empty and full reported together");

endmodule

bind byte_ring_buffer brb_chk u_brb_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (cmd.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .byte_out   (rsp.byte_out),
  .status     (rsp.status),
  .done_count (rsp.done_count),
  .last       (rsp.last),
  .fill_count (rsp.fill_count),
  .is_empty   (rsp.is_empty),
  .is_full    (rsp.is_full)
);

`default_nettype wire

// ===== bench/byte_ring_buffer_tb.sv =====
// Self-checking testbench for byte_ring_buffer: directed corners and random put/get/peek/drop/clear traffic
// over several capacity settings, checked against a behavioral ring model.
// Depends on brb_pkg, brb_if and the byte_ring_buffer RTL.
`timescale 1ns / 100ps

module byte_ring_buffer_tb;
  import brb_pkg::*;

  localparam kind_t KIND_BAD_LO = 3'd5;
  localparam kind_t KIND_BAD_HI = 3'd7;
  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    kind_t kind;
    byte_t data;
    logic  last;
    len_t  len;
  } ring_op_t;

  typedef struct {
    byte_t   b;
    status_t st;
    len_t    done;
    logic    last;
    len_t    fill;
    logic    empty;
    logic    full;
  } ring_result_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  brb_in_if  cmd ();
  brb_out_if rsp ();

  byte_ring_buffer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd), .rsp(rsp)
  );

  // Behavioral copy of the ring.
  byte_t       ring_bytes [DEPTH_DEF];
  int unsigned cap_slots, wr_pos, rd_pos, held, run_len;

  ring_op_t     pending_ops[$];
  ring_result_t expected_results[$];
  ring_op_t     drv_op;
  ring_op_t     seen_op;
  ring_result_t want;

  int  fail_count, op_count, result_count, refused_puts, setting_count;
  int  quiet_cycles, hold_left;
  logic calm, hold_req;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_error(string msg);
    if (fail_count < 40) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic int unsigned step_pos(int unsigned i);
    return (i + 1 >= cap_slots) ? 0 : i + 1;
  endfunction

  function automatic void push_result(byte_t b, status_t st, int unsigned done, logic lst);
    ring_result_t r;
    r.b     = b;
    r.st    = st;
    r.done  = len_t'(done);
    r.last  = lst;
    r.fill  = len_t'(held);
    r.empty = (held == 0);
    r.full  = (held == cap_slots);
    expected_results.push_back(r);
  endfunction

  function automatic void model_transaction(ring_op_t op);
    int unsigned n, i, p, req;
    status_t st;
    if (op.kind == KIND_PUT) begin
      st = ST_NONE;
      if (held < cap_slots) begin
        ring_bytes[wr_pos] = op.data;
        wr_pos = step_pos(wr_pos);
        held++;
        if (run_len < RUN_MAX) run_len++;
        st = ST_DONE;
      end else begin
        refused_puts++;
      end
      if (op.last) begin
        n = run_len;
        run_len = 0;
        push_result('0, (n == 0) ? ST_NONE : ST_DONE, n, 1'b1);
      end else begin
        push_result('0, st, run_len, 1'b0);
      end
    end else if (op.kind == KIND_CLEAR) begin
      // Clear leaves an open put call running.
      wr_pos = 0;
      rd_pos = 0;
      held = 0;
      push_result('0, ST_DONE, 0, 1'b1);
    end else if (op.kind > KIND_CLEAR || op.len == 0) begin
      push_result('0, ST_BAD, 0, 1'b1);
    end else if (held == 0) begin
      push_result('0, ST_NONE, 0, 1'b1);
    end else if (op.kind == KIND_DROP) begin
      n = (op.len > held) ? held : op.len;
      for (i = 0; i < n; i++) rd_pos = step_pos(rd_pos);
      held -= n;
      push_result('0, ST_DONE, n, 1'b1);
    end else begin
      req = (op.len > MAX_BURST_DEF) ? MAX_BURST_DEF : op.len;
      n = (req > held) ? held : req;
      if (op.kind == KIND_GET) held -= n;
      p = rd_pos;
      for (i = 0; i < n; i++) begin
        push_result(ring_bytes[p], ST_DONE, n, (i + 1 == n));
        p = step_pos(p);
      end
      if (op.kind == KIND_GET) rd_pos = p;
    end
  endfunction

  task automatic add_op(kind_t k, byte_t d, logic lst, len_t n);
    ring_op_t op;
    op.kind = k;
    op.data = d;
    op.last = lst;
    op.len  = n;
    pending_ops.push_back(op);
  endtask

  function automatic len_t pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return len_t'(DEPTH_DEF);
    if (r < 15) return len_t'($urandom_range(0, DEPTH_DEF));
    return len_t'($urandom_range(1, 70));
  endfunction

  function automatic kind_t pick_read_kind();
    int r;
    r = $urandom_range(2);
    return (r == 0) ? KIND_GET : (r == 1) ? KIND_PEEK : KIND_DROP;
  endfunction

  // Mostly complete put calls with reads between them; a little noise on the side.
  task automatic queue_random(int count);
    int made, r, call_len, j;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 50) begin
        call_len = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        for (j = 0; j < call_len; j++) begin
          if ($urandom_range(19) == 0) begin
            add_op(pick_read_kind(), byte_t'($urandom), 1'($urandom_range(1)), pick_len());
            made++;
          end
          add_op(KIND_PUT, byte_t'($urandom), j == call_len - 1,
                 len_t'($urandom_range(0, DEPTH_DEF)));
        end
        made += call_len;
      end else if (r < 70) begin
        add_op(KIND_GET, byte_t'($urandom), 1'($urandom_range(1)), pick_len());
        made++;
      end else if (r < 82) begin
        add_op(KIND_PEEK, byte_t'($urandom), 1'($urandom_range(1)), pick_len());
        made++;
      end else if (r < 92) begin
        add_op(KIND_DROP, byte_t'($urandom), 1'($urandom_range(1)), pick_len());
        made++;
      end else if (r < 95) begin
        add_op(KIND_CLEAR, byte_t'($urandom), 1'($urandom_range(1)), pick_len());
        made++;
      end else begin
        if ($urandom_range(1) == 0)
          add_op(kind_t'($urandom_range(KIND_BAD_LO, KIND_BAD_HI)), byte_t'($urandom), 1'b0,
                 pick_len());
        else
          add_op(pick_read_kind(), byte_t'($urandom), 1'b0, '0);
        made++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (pending_ops.size() != 0 || cmd.valid
                              || expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(int unsigned value);
    int unsigned v;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = value & RUN_MAX;
    if (v == 0) v = 1;
    if (v > DEPTH_DEF) v = DEPTH_DEF;
    cap_slots = v;
    wr_pos = 0;
    rd_pos = 0;
    held = 0;
    run_len = 0;
    setting_count++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd.ready) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
        drv_op = pending_ops.pop_front();
        cmd.valid       <= 1'b1;
        cmd.kind        <= drv_op.kind;
        cmd.data_byte   <= drv_op.data;
        cmd.data_last   <= drv_op.last;
        cmd.request_len <= drv_op.len;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      rsp.ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      rsp.ready <= calm || $urandom_range(99) >= 16;
    end
  end

  // Monitor: check the result first, since it always belongs to an older transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result byte %0h status %0d done %0d",
                                 rsp.byte_out, rsp.status, rsp.done_count));
        end else begin
          want = expected_results.pop_front();
          if (rsp.byte_out !== want.b || rsp.status !== want.st
              || rsp.done_count !== want.done || rsp.last !== want.last
              || rsp.fill_count !== want.fill || rsp.is_empty !== want.empty
              || rsp.is_full !== want.full)
            report_error($sformatf(
              "got b %0h st %0d done %0d last %0b fill %0d e%0b f%0b, want %0h %0d %0d %0b %0d %0b %0b",
              rsp.byte_out, rsp.status, rsp.done_count, rsp.last, rsp.fill_count,
              rsp.is_empty, rsp.is_full, want.b, want.st, want.done, want.last, want.fill,
              want.empty, want.full));
        end
      end
      if (cmd.valid && cmd.ready) begin
        seen_op.kind = cmd.kind;
        seen_op.data = cmd.data_byte;
        seen_op.last = cmd.data_last;
        seen_op.len  = cmd.request_len;
        model_transaction(seen_op);
        op_count++;
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd.valid = 1'b0;
    cmd.kind = KIND_PUT;
    cmd.data_byte = '0;
    cmd.data_last = 1'b0;
    cmd.request_len = '0;
    rsp.ready = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    fail_count = 0;
    op_count = 0;
    result_count = 0;
    refused_puts = 0;
    setting_count = 0;
    quiet_cycles = 0;
    cap_slots = DEPTH_DEF;
    wr_pos = 0;
    rd_pos = 0;
    held = 0;
    run_len = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Capacity as it comes out of reset.
    queue_random(12);
    wait_quiet();

    // Directed corners on a five-slot store.
    write_capacity(5);
    add_op(KIND_GET, 8'h00, 1'b0, 13'd1);
    add_op(KIND_DROP, 8'h00, 1'b0, len_t'(DEPTH_DEF));
    add_op(KIND_PEEK, 8'hFF, 1'b1, 13'd0);
    add_op(KIND_BAD_LO, 8'h00, 1'b0, 13'd3);
    add_op(KIND_BAD_HI, 8'hFF, 1'b1, RUN_MAX);
    add_op(KIND_PUT, 8'h00, 1'b0, 13'd0);
    add_op(KIND_PUT, 8'hFF, 1'b0, RUN_MAX);
    add_op(KIND_PEEK, 8'h00, 1'b0, 13'd1);
    add_op(KIND_PUT, 8'hA5, 1'b0, 13'd0);
    add_op(KIND_PUT, 8'h5A, 1'b0, 13'd0);
    add_op(KIND_PUT, 8'h3C, 1'b0, 13'd0);
    add_op(KIND_PUT, 8'h11, 1'b0, 13'd0);
    add_op(KIND_PUT, 8'h22, 1'b1, 13'd0);
    add_op(KIND_PUT, 8'h33, 1'b1, 13'd0);
    add_op(KIND_PEEK, 8'h00, 1'b0, len_t'(DEPTH_DEF));
    add_op(KIND_GET, 8'h00, 1'b0, 13'd2);
    add_op(KIND_DROP, 8'h00, 1'b0, 13'd1);
    add_op(KIND_PUT, 8'h77, 1'b0, 13'd0);
    add_op(KIND_CLEAR, 8'h00, 1'b0, 13'd0);
    add_op(KIND_PUT, 8'h88, 1'b1, 13'd0);
    add_op(KIND_PUT, 8'h99, 1'b0, 13'd0);
    add_op(KIND_DROP, 8'h00, 1'b0, 13'd40);
    add_op(KIND_GET, 8'h00, 1'b0, len_t'(DEPTH_DEF));
    add_op(KIND_GET, 8'h00, 1'b0, 13'd1);
    queue_random(30);
    wait_quiet();

    write_capacity(1);
    queue_random(25);
    wait_quiet();

    // Zero acts as a single slot.
    write_capacity(0);
    queue_random(15);
    wait_quiet();

    // Above the array size clamps to full depth; first a stretch with no idling.
    write_capacity(RUN_MAX);
    calm = 1'b1;
    queue_random(40);
    wait_quiet();
    calm = 1'b0;
    for (int c = 0; c < 60; c++)
      add_op(KIND_PUT, byte_t'($urandom), (c % 10) == 9, '0);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    queue_random(20);
    wait_quiet();

    write_capacity(17);
    queue_random(35);
    wait_quiet();

    write_capacity(MAX_BURST_DEF);
    queue_random(30);
    wait_quiet();

    write_capacity(DEPTH_DEF);
    queue_random(20);
    wait_quiet();

    repeat (20) @(negedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Covered %0d transactions over %0d capacity settings, %0d results checked;",
             op_count, setting_count, result_count);
    $display("%0d put bytes were turned away by a full store.", refused_puts);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
